// File: rtl/image_3x3_edge_sharpen_filter_assert.svh
// assertion macros shared by the checker of the 3x3 edge and sharpen filter
// expects clk and rst_n in the scope of the file that includes it
`ifndef IMAGE_3X3_EDGE_SHARPEN_FILTER_ASSERT_SVH
`define IMAGE_3X3_EDGE_SHARPEN_FILTER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define I3ES_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define I3ES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/i3es_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the 3x3 edge and sharpen filter
// no dependencies
package i3es_pkg;

    localparam int PIX_W       = 8;
    localparam int COUNT_W     = 11;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int MAX_HEIGHT  = 1024;
    localparam int QUEUE_DEPTH = 4;

    typedef logic [PIX_W-1:0]       pix_t;
    typedef logic [COUNT_W-1:0]     count_t;
    typedef logic [MODE_W-1:0]      mode_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam mode_t MODE_HALF_SUM  = 2'd0;
    localparam mode_t MODE_MAGNITUDE = 2'd1;
    localparam mode_t MODE_SHARPEN   = 2'd2;

    localparam cfg_index_t CFG_WIDTH  = 2'd0;
    localparam cfg_index_t CFG_HEIGHT = 2'd1;
    localparam cfg_index_t CFG_MODE   = 2'd2;

    localparam pix_t PIX_MAX = 8'd255;

    // border-masked neighbourhood, row then column, plus end-of-image mark
    typedef struct packed {
        pix_t [2:0][2:0] nb;
        logic            frame_end;
    } work_t;

endpackage

// File: rtl/image_3x3_edge_sharpen_filter.sv
`timescale 1ns / 1ps
// 3x3 edge and sharpen filter for an 8-bit grayscale raster stream, top level; uses
// i3es_pkg, i3es_front, i3es_queue and i3es_back. Each result is the filtered pixel one
// row and one column behind the input, so it leaves image_width+1 input transactions after
// its pixel came in; after the last pixel of an image send image_width+1 zero pixels to
// drain. The front takes one pixel per clock, reading the line store at intake and writing
// it back when that pixel leaves the intake register, and stalls only while the queue is
// full. The back end takes one neighbourhood at a time and the next only once its result
// is in the output register: gradient, evaluation, and in the magnitude mode squares and
// an 8-step bit-serial root (skipped, giving 255, when the sum of squares reaches 65536);
// a 4-entry queue and the output register take up bursts. The line stores are not cleared
// after reset: a fill mark tracks how many columns have been written so far and cells
// past it read as zero.
module image_3x3_edge_sharpen_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  i3es_pkg::pix_t       s_axis_tdata,   // [7:0] pixel
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output i3es_pkg::pix_t       m_axis_tdata,   // [7:0] filtered_pixel
    output logic                 m_axis_tlast,   // frame_end
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  i3es_pkg::cfg_index_t cfg_index,
    input  i3es_pkg::count_t     cfg_data
);
    import i3es_pkg::*;

    localparam count_t WIDTH_RESET  = 11'd640;
    localparam count_t HEIGHT_RESET = 11'd480;

    count_t image_width_reg;
    count_t image_height_reg;
    mode_t  filter_mode_reg;

    logic   push_valid;
    logic   push_ready;
    work_t  push_data;
    logic   pop_valid;
    logic   pop_ready;
    work_t  pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            filter_mode_reg  <= MODE_HALF_SUM;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIDTH:  image_width_reg  <= cfg_data;
                CFG_HEIGHT: image_height_reg <= cfg_data;
                CFG_MODE:   filter_mode_reg  <= cfg_data[MODE_W-1:0];
                default:    ;
            endcase
        end
    end

    i3es_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_pixel     (s_axis_tdata),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    i3es_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    i3es_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .filter_mode (filter_mode_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_pixel   (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

endmodule

// File: rtl/i3es_front.sv
`timescale 1ns / 1ps
// front end: pixel intake, raster counters, line stores, 3x3 window, border masking
// depends on i3es_pkg
module i3es_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  i3es_pkg::count_t image_width,
    input  i3es_pkg::count_t image_height,
    input  logic             in_valid,
    output logic             in_ready,
    input  i3es_pkg::pix_t   in_pixel,
    output logic             push_valid,
    input  logic             push_ready,
    output i3es_pkg::work_t  push_data
);
    import i3es_pkg::*;

    localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCAP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;

    typedef logic [AW-1:0] addr_t;
    typedef logic [AW:0]   fill_t;

    typedef struct packed {
        pix_t upper;
        pix_t middle;
    } line_t;

    typedef struct packed {
        logic valid;
        logic top;
        logic bottom;
        logic left;
        logic right;
    } flags_t;

    line_t  line_mem [MAX_WIDTH];

    count_t col_reg;
    count_t row_reg;
    count_t col_next;
    count_t row_next;
    count_t w_eff;
    count_t h_eff;
    count_t c;
    count_t r;
    count_t rq;
    count_t cq;
    logic   restart;
    logic   accept;
    logic   b_adv;
    logic   bypass;
    flags_t flags;
    addr_t  addr_a;

    logic   s1_valid_reg;
    pix_t   s1_pix_reg;
    addr_t  s1_addr_reg;
    flags_t s1_flags_reg;
    line_t  rd_reg;
    logic   rd_blank_reg;
    line_t  rd_line;
    fill_t  fill_reg;

    pix_t [2:0][2:0] win_reg;
    pix_t [2:0][2:0] win_new;

    // geometry in use and position of the incoming pixel
    always_comb
    begin
        w_eff = image_width;
        if (image_width == '0)
        begin
            w_eff = COUNT_W'(1);
        end
        else if (image_width > COUNT_W'(WCAP))
        begin
            w_eff = COUNT_W'(WCAP);
        end
        h_eff = image_height;
        if (image_height == '0)
        begin
            h_eff = COUNT_W'(1);
        end
        else if (image_height > COUNT_W'(MAX_HEIGHT))
        begin
            h_eff = COUNT_W'(MAX_HEIGHT);
        end

        restart = (col_reg >= w_eff) || (row_reg > h_eff + COUNT_W'(1));
        c = restart ? '0 : col_reg;
        r = restart ? '0 : row_reg;

        if (c != '0)
        begin
            flags.valid = (r >= COUNT_W'(1)) && (r <= h_eff);
            rq = r - COUNT_W'(1);
            cq = c - COUNT_W'(1);
        end
        else
        begin
            flags.valid = (r >= COUNT_W'(2)) && (r <= h_eff + COUNT_W'(1));
            rq = r - COUNT_W'(2);
            cq = w_eff - COUNT_W'(1);
        end
        flags.top    = (rq == '0);
        flags.bottom = (rq == h_eff - COUNT_W'(1));
        flags.left   = (cq == '0);
        flags.right  = (cq == w_eff - COUNT_W'(1));

        if (c + COUNT_W'(1) >= w_eff)
        begin
            col_next = '0;
            row_next = r + COUNT_W'(1);
        end
        else
        begin
            col_next = c + COUNT_W'(1);
            row_next = r;
        end
        // last result of the image: start over
        if (flags.valid && flags.bottom && flags.right)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    assign addr_a     = AW'(c);
    assign b_adv      = s1_valid_reg && (!s1_flags_reg.valid || push_ready);
    assign in_ready   = !s1_valid_reg || b_adv;
    assign accept     = in_valid && in_ready;
    assign push_valid = s1_valid_reg && s1_flags_reg.valid;
    assign bypass     = b_adv && (s1_addr_reg == addr_a);
    assign rd_line    = rd_blank_reg ? '0 : rd_reg;

    // shift in the new right column and mask the border
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_new[i][0] = win_reg[i][1];
            win_new[i][1] = win_reg[i][2];
        end
        win_new[0][2] = rd_line.upper;
        win_new[1][2] = rd_line.middle;
        win_new[2][2] = s1_pix_reg;

        push_data.nb = win_new;
        for (int j = 0; j < 3; j++)
        begin
            if (s1_flags_reg.top)
            begin
                push_data.nb[0][j] = '0;
            end
            if (s1_flags_reg.bottom)
            begin
                push_data.nb[2][j] = '0;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (s1_flags_reg.left)
            begin
                push_data.nb[i][0] = '0;
            end
            if (s1_flags_reg.right)
            begin
                push_data.nb[i][2] = '0;
            end
        end
        push_data.frame_end = s1_flags_reg.bottom && s1_flags_reg.right;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (b_adv)
            begin
                win_reg <= win_new;
            end
            // columns are written in order from zero, so the written cells form a prefix
            if (b_adv && (fill_t'(s1_addr_reg) >= fill_reg))
            begin
                fill_reg <= fill_t'(s1_addr_reg) + fill_t'(1);
            end
        end
    end

    // line store: read at intake, write back when the intake stage advances, bypass on same
    // column, cells past the fill mark read as zero
    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            line_mem[s1_addr_reg] <= {rd_line.middle, s1_pix_reg};
        end
        if (accept)
        begin
            if (bypass)
            begin
                rd_reg       <= {rd_line.middle, s1_pix_reg};
                rd_blank_reg <= 1'b0;
            end
            else
            begin
                rd_reg       <= line_mem[addr_a];
                rd_blank_reg <= (fill_t'(addr_a) >= fill_reg);
            end
            s1_pix_reg   <= in_pixel;
            s1_addr_reg  <= addr_a;
            s1_flags_reg <= flags;
        end
    end

endmodule

// File: rtl/i3es_queue.sv
`timescale 1ns / 1ps
// small queue of masked neighbourhoods between front and back
// depends on i3es_pkg
module i3es_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  i3es_pkg::work_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output i3es_pkg::work_t pop_data
);
    import i3es_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    work_t          store [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/i3es_back.sv
`timescale 1ns / 1ps
// back end: sobel gradients, half sum, sharpen, bit-serial square root, clamp, output register
// depends on i3es_pkg
module i3es_back (
    input  logic            clk,
    input  logic            rst_n,
    input  i3es_pkg::mode_t filter_mode,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  i3es_pkg::work_t pop_data,
    output logic            out_valid,
    input  logic            out_ready,
    output i3es_pkg::pix_t  out_pixel,
    output logic            out_last
);
    import i3es_pkg::*;

    localparam int ROOT_STEPS = PIX_W;
    localparam int SW         = $clog2(ROOT_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GRAD,
        ST_EVAL,
        ST_ROOT,
        ST_OUT
    } state_t;

    state_t              state_reg;
    work_t               work_reg;
    logic signed [10:0]  gx_reg;
    logic signed [10:0]  gy_reg;
    logic signed [11:0]  sharp_reg;
    logic [15:0]         rad_reg;
    logic [9:0]          rem_reg;
    logic [7:0]          root_reg;
    logic                over_reg;
    logic [SW-1:0]       step_reg;
    pix_t                res_reg;
    logic                out_valid_reg;
    pix_t                out_pixel_reg;
    logic                out_last_reg;

    logic [9:0]          top_sum;
    logic [9:0]          bot_sum;
    logic [9:0]          left_sum;
    logic [9:0]          right_sum;
    logic [9:0]          cross_sum;
    logic signed [10:0]  gx;
    logic signed [10:0]  gy;
    logic signed [11:0]  sharp;
    logic signed [11:0]  grad_sum;
    logic signed [11:0]  half;
    logic signed [21:0]  gx_sq;
    logic signed [21:0]  gy_sq;
    logic [21:0]         sq_full;
    logic [11:0]         cur;
    logic [11:0]         trial;
    logic                ge;
    logic [9:0]          rem_step;
    logic [7:0]          root_step;
    logic                out_load;

    function automatic pix_t clamp_byte(input logic signed [11:0] v);
        pix_t res;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > 12'sd255)
        begin
            res = PIX_MAX;
        end
        else
        begin
            res = v[7:0];
        end
        return res;
    endfunction

    always_comb
    begin
        top_sum   = {2'b0, work_reg.nb[0][0]} + {1'b0, work_reg.nb[0][1], 1'b0}
                  + {2'b0, work_reg.nb[0][2]};
        bot_sum   = {2'b0, work_reg.nb[2][0]} + {1'b0, work_reg.nb[2][1], 1'b0}
                  + {2'b0, work_reg.nb[2][2]};
        left_sum  = {2'b0, work_reg.nb[0][0]} + {1'b0, work_reg.nb[1][0], 1'b0}
                  + {2'b0, work_reg.nb[2][0]};
        right_sum = {2'b0, work_reg.nb[0][2]} + {1'b0, work_reg.nb[1][2], 1'b0}
                  + {2'b0, work_reg.nb[2][2]};
        cross_sum = {2'b0, work_reg.nb[0][1]} + {2'b0, work_reg.nb[1][0]}
                  + {2'b0, work_reg.nb[1][2]} + {2'b0, work_reg.nb[2][1]};
        gy    = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
        gx    = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
        sharp = $signed({2'b0, work_reg.nb[1][1], 2'b0}) + $signed({4'b0, work_reg.nb[1][1]})
              - $signed({2'b0, cross_sum});

        // half sum, truncated toward zero
        grad_sum = $signed({gx_reg[10], gx_reg}) + $signed({gy_reg[10], gy_reg});
        half     = (grad_sum + $signed({11'b0, grad_sum[11]})) >>> 1;

        gx_sq   = gx_reg * gx_reg;
        gy_sq   = gy_reg * gy_reg;
        sq_full = $unsigned(gx_sq) + $unsigned(gy_sq);

        // one root digit per cycle
        cur       = {rem_reg, rad_reg[15:14]};
        trial     = {2'b0, root_reg, 2'b01};
        ge        = (cur >= trial);
        rem_step  = ge ? 10'(cur - trial) : cur[9:0];
        root_step = {root_reg[6:0], ge};
    end

    assign pop_ready = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            work_reg      <= '0;
            gx_reg        <= '0;
            gy_reg        <= '0;
            sharp_reg     <= '0;
            rad_reg       <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            over_reg      <= 1'b0;
            step_reg      <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_pixel_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_pixel_reg <= res_reg;
                out_last_reg  <= work_reg.frame_end;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop_valid)
                    begin
                        work_reg  <= pop_data;
                        state_reg <= ST_GRAD;
                    end
                end
                ST_GRAD:
                begin
                    gx_reg    <= gx;
                    gy_reg    <= gy;
                    sharp_reg <= sharp;
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    case (filter_mode)
                        MODE_HALF_SUM:
                        begin
                            res_reg   <= clamp_byte(half);
                            state_reg <= ST_OUT;
                        end
                        MODE_MAGNITUDE:
                        begin
                            rad_reg   <= sq_full[15:0];
                            over_reg  <= |sq_full[21:16];
                            rem_reg   <= '0;
                            root_reg  <= '0;
                            step_reg  <= '0;
                            state_reg <= ST_ROOT;
                        end
                        MODE_SHARPEN:
                        begin
                            res_reg   <= clamp_byte(sharp_reg);
                            state_reg <= ST_OUT;
                        end
                        default:
                        begin
                            res_reg   <= '0;
                            state_reg <= ST_OUT;
                        end
                    endcase
                end
                ST_ROOT:
                begin
                    if (over_reg)
                    begin
                        res_reg   <= PIX_MAX;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        rem_reg  <= rem_step;
                        root_reg <= root_step;
                        rad_reg  <= {rad_reg[13:0], 2'b00};
                        step_reg <= step_reg + SW'(1);
                        if (step_reg == SW'(ROOT_STEPS - 1))
                        begin
                            res_reg   <= root_step;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/i3es_checker.sv
`timescale 1ns / 1ps
// port-level checker of the 3x3 edge and sharpen filter, bound to the top level
// depends on image_3x3_edge_sharpen_filter_assert.svh
`include "image_3x3_edge_sharpen_filter_assert.svh"

module i3es_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    logic [31:0] in_count_reg;
    logic [31:0] out_count_reg;
    logic [31:0] pending;
    logic        in_xfer;
    logic        out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign pending  = in_count_reg - out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                in_count_reg <= in_count_reg + 32'd1;
            end
            if (out_xfer)
            begin
                out_count_reg <= out_count_reg + 32'd1;
            end
        end
    end

    // a stalled result holds
    `I3ES_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

    // every result comes from an earlier input transaction
    `I3ES_ASSERT_IMPL(a_result_has_cause, out_xfer, pending != 32'd0, "result without a pending input")

    // intake blocks only while the pixel taken just before is still held
    `I3ES_ASSERT_IMPL(a_ready_drop, !s_axis_tready, $past(in_xfer) || $past(!s_axis_tready), "intake stalled with no pixel held")

endmodule

bind image_3x3_edge_sharpen_filter i3es_checker u_checker (.*);

// File: verif/tb_image_3x3_edge_sharpen_filter.sv
`timescale 1ns / 1ps
// self-checking testbench for the 3x3 edge and sharpen filter: raster images of many
// geometries in every mode, each result checked against an in-bench model of the filter
// depends on i3es_pkg and image_3x3_edge_sharpen_filter
module tb_image_3x3_edge_sharpen_filter;
    import i3es_pkg::*;

    localparam int LINE_DEPTH      = 1024;
    localparam int DRAIN_CYCLES    = 150;
    localparam int IDLE_LIMIT      = 200000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_ITEMS    = 1040;
    localparam int MAX_REPORTS     = 40;

    localparam mode_t MODE_UNUSED = 2'd3;

    typedef enum int {PIX_ZERO, PIX_ALTERNATE, PIX_RANDOM} pix_style_t;

    typedef struct packed {
        pix_t filtered;
        logic frame_end;
    } filt_result_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    pix_t       s_axis_tdata  = '0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    pix_t       m_axis_tdata;
    logic       m_axis_tlast;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index     = CFG_WIDTH;
    count_t     cfg_data      = '0;

    // filter model state
    pix_t   upper_line [LINE_DEPTH];
    pix_t   middle_line [LINE_DEPTH];
    pix_t   win [3][3];
    int     col_pos = 0;
    int     row_pos = 0;
    count_t width_reg  = 11'd640;
    count_t height_reg = 11'd480;
    mode_t  mode_reg   = MODE_HALF_SUM;

    pix_t         pixel_feed [$];
    filt_result_t predicted_pixels [$];

    bit pix_taken = 1'b0;
    bit cfg_taken = 1'b0;
    bit tx_gaps   = 1'b1;
    bit rx_stalls = 1'b1;
    int burst_left = 1;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int mismatch_count = 0;
    int report_count = 0;

    image_3x3_edge_sharpen_filter #(
        .MAX_WIDTH(LINE_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit predict_filtered_pixel(input pix_t pix, output filt_result_t res);
        int w;
        int h;
        int c;
        int r;
        int rq;
        int cq;
        int gx;
        int gy;
        int acc;
        int sq;
        int n [3][3];
        bit ok;
        w = width_reg;
        h = height_reg;
        if (w == 0) w = 1;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        // geometry changed under a running image
        if (col_pos >= w || row_pos > h + 1)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = middle_line[c];
        win[2][2] = pix;
        upper_line[c] = middle_line[c];
        middle_line[c] = pix;
        if (c >= 1)
        begin
            ok = (r >= 1) && (r <= h);
            rq = r - 1;
            cq = c - 1;
        end
        else
        begin
            ok = (r >= 2) && (r <= h + 1);
            rq = r - 2;
            cq = w - 1;
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1) % 2048;
        end
        else
        begin
            col_pos = c + 1;
        end
        res = '0;
        if (!ok)
            return 1'b0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                n[i][j] = win[i][j];
        // neighbors outside the image read as zero
        if (rq == 0)
            for (int j = 0; j < 3; j++) n[0][j] = 0;
        if (rq == h - 1)
            for (int j = 0; j < 3; j++) n[2][j] = 0;
        if (cq == 0)
            for (int i = 0; i < 3; i++) n[i][0] = 0;
        if (cq == w - 1)
            for (int i = 0; i < 3; i++) n[i][2] = 0;
        gy = (n[0][0] + 2 * n[0][1] + n[0][2]) - (n[2][0] + 2 * n[2][1] + n[2][2]);
        gx = (n[0][0] + 2 * n[1][0] + n[2][0]) - (n[0][2] + 2 * n[1][2] + n[2][2]);
        case (mode_reg)
            MODE_HALF_SUM:
                acc = (gx + gy) / 2;
            MODE_MAGNITUDE:
            begin
                sq = gx * gx + gy * gy;
                if (sq >= 65536)
                    acc = 255;
                else
                begin
                    acc = 0;
                    while ((acc + 1) * (acc + 1) <= sq)
                        acc++;
                end
            end
            MODE_SHARPEN:
                acc = 5 * n[1][1] - n[0][1] - n[1][0] - n[1][2] - n[2][1];
            default:
                acc = 0;
        endcase
        if (acc < 0)
            acc = 0;
        else if (acc > 255)
            acc = 255;
        res.filtered = pix_t'(acc);
        res.frame_end = (rq == h - 1) && (cq == w - 1);
        if (res.frame_end)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        return 1'b1;
    endfunction

    // prediction and checking on the rising edge
    always @(posedge clk)
    begin
        filt_result_t want;
        pix_taken <= s_axis_tvalid && s_axis_tready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg = cfg_data;
                    CFG_HEIGHT: height_reg = cfg_data;
                    CFG_MODE:   mode_reg = mode_t'(cfg_data[MODE_W-1:0]);
                    default:    ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (predict_filtered_pixel(s_axis_tdata, want))
                    predicted_pixels.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (predicted_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (report_count++ < MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual %0d last %0b",
                                 $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = predicted_pixels.pop_front();
                    if (m_axis_tdata !== want.filtered)
                    begin
                        mismatch_count++;
                        if (report_count++ < MAX_REPORTS)
                            $display("%0t: filtered_pixel mismatch, expected %0d, actual %0d",
                                     $time, want.filtered, m_axis_tdata);
                    end
                    if (m_axis_tlast !== want.frame_end)
                    begin
                        mismatch_count++;
                        if (report_count++ < MAX_REPORTS)
                            $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                                     $time, want.frame_end, m_axis_tlast);
                    end
                end
            end
        end
    end

    // pixel driver, bursts with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (pix_taken)
            begin
                void'(pixel_feed.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 32);
                    gap_left = (!tx_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!s_axis_tvalid || pix_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pixel_feed.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pixel_feed[0];
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver, short random stalls and an occasional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_OFF_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (rx_stalls && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 6);
        end
    end

    task automatic write_reg(input cfg_index_t idx, input count_t val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int w, input int h, input mode_t m);
        write_reg(CFG_WIDTH, count_t'(w));
        write_reg(CFG_HEIGHT, count_t'(h));
        write_reg(CFG_MODE, count_t'(m));
    endtask

    task automatic push_frame(input int count, input pix_style_t style);
        pix_t p;
        for (int k = 0; k < count; k++)
        begin
            case (style)
                PIX_ZERO:      p = '0;
                PIX_ALTERNATE: p = k[0] ? PIX_MAX : '0;
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       p = '0;
                        1:       p = PIX_MAX;
                        default: p = pix_t'($urandom_range(0, 255));
                    endcase
                end
            endcase
            pixel_feed.push_back(p);
        end
    endtask

    // wait for the stream to drain, then for the back end to settle
    task automatic wait_idle();
        int waited;
        waited = 0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while ((pixel_feed.size() != 0 || s_axis_tvalid || predicted_pixels.size() != 0)
               && waited < IDLE_LIMIT);
        if (waited >= IDLE_LIMIT)
        begin
            mismatch_count++;
            $display("%0t: stream stuck, expected 0 results pending, actual %0d", $time,
                     predicted_pixels.size());
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        mode_t all_modes [4];
        int random_count;
        int w;
        int h;
        int n;
        int kind;
        all_modes = '{MODE_HALF_SUM, MODE_MAGNITUDE, MODE_SHARPEN, MODE_UNUSED};
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // tiny images in every mode, extreme pixels
        for (int m = 0; m < 4; m++)
        begin
            configure(2, 2, all_modes[m]);
            push_frame(4, PIX_ALTERNATE);
            push_frame(3, PIX_ZERO);
            wait_idle();
        end
        // zero sizes behave as one
        configure(0, 0, MODE_SHARPEN);
        push_frame(1, PIX_RANDOM);
        push_frame(2, PIX_ZERO);
        wait_idle();

        // geometry change in the middle of an image
        configure(20, 10, MODE_SHARPEN);
        push_frame(5 * 20 + 12, PIX_RANDOM);
        wait_idle();
        configure(8, 3, MODE_HALF_SUM);
        push_frame(24, PIX_RANDOM);
        push_frame(9, PIX_ZERO);
        wait_idle();

        // long receiver hold-off with the sender pushing back to back
        tx_gaps = 1'b0;
        configure(12, 10, MODE_MAGNITUDE);
        hold_requests++;
        push_frame(120, PIX_RANDOM);
        push_frame(13, PIX_ZERO);
        wait_idle();

        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            w = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
            h = (w > 24) ? $urandom_range(1, 3) : $urandom_range(1, 10);
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            configure(w, h, all_modes[($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2)]);
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                n = w * h + w + 1;
                push_frame(w * h, PIX_RANDOM);
                push_frame(w + 1, PIX_ZERO);
            end
            else if (kind == 8)
            begin
                // truncated image
                n = $urandom_range(1, w * h + w);
                push_frame(n, PIX_RANDOM);
            end
            else
            begin
                // noisy padding running past the end of the image
                n = w * h + w + 1 + $urandom_range(1, 2 * w);
                push_frame(w * h, PIX_RANDOM);
                push_frame(n - w * h, PIX_RANDOM);
            end
            random_count += n;
            wait_idle();
        end

        if (mismatch_count == 0 && predicted_pixels.size() == 0)
            $display("tb_image_3x3_edge_sharpen_filter: PASS");
        else
            $display("tb_image_3x3_edge_sharpen_filter: FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb_image_3x3_edge_sharpen_filter: FAIL");
        $finish;
    end

endmodule
